FILE: rtl/core/packet_header_field_extractor_macros.svh
// assertion macros for the packet header field extractor
`ifndef PACKET_HEADER_FIELD_EXTRACTOR_MACROS_SVH
`define PACKET_HEADER_FIELD_EXTRACTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PHFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PHFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/phfe_pkg.sv
// types, field codes and decode helpers shared by the header extractor
`timescale 1ns / 1ps
`default_nettype none

package phfe_pkg;

  localparam int MaxRes = 6;

  // match field codes
  localparam logic [5:0] FC_IN_PORT     = 6'd0;
  localparam logic [5:0] FC_METADATA    = 6'd1;
  localparam logic [5:0] FC_ETH_DST     = 6'd2;
  localparam logic [5:0] FC_ETH_SRC     = 6'd3;
  localparam logic [5:0] FC_ETH_TYPE    = 6'd4;
  localparam logic [5:0] FC_VLAN_VID    = 6'd5;
  localparam logic [5:0] FC_VLAN_PCP    = 6'd6;
  localparam logic [5:0] FC_IP_DSCP     = 6'd7;
  localparam logic [5:0] FC_IP_ECN      = 6'd8;
  localparam logic [5:0] FC_IP_PROTO    = 6'd9;
  localparam logic [5:0] FC_IPV4_SRC    = 6'd10;
  localparam logic [5:0] FC_IPV4_DST    = 6'd11;
  localparam logic [5:0] FC_TCP_SRC     = 6'd12;
  localparam logic [5:0] FC_TCP_DST     = 6'd13;
  localparam logic [5:0] FC_UDP_SRC     = 6'd14;
  localparam logic [5:0] FC_UDP_DST     = 6'd15;
  localparam logic [5:0] FC_SCTP_SRC    = 6'd16;
  localparam logic [5:0] FC_SCTP_DST    = 6'd17;
  localparam logic [5:0] FC_ICMP4_TYPE  = 6'd18;
  localparam logic [5:0] FC_ICMP4_CODE  = 6'd19;
  localparam logic [5:0] FC_ARP_OP      = 6'd20;
  localparam logic [5:0] FC_ARP_SPA     = 6'd21;
  localparam logic [5:0] FC_ARP_TPA     = 6'd22;
  localparam logic [5:0] FC_ARP_SHA     = 6'd23;
  localparam logic [5:0] FC_ARP_THA     = 6'd24;
  localparam logic [5:0] FC_IPV6_SRC    = 6'd25;
  localparam logic [5:0] FC_IPV6_DST    = 6'd26;
  localparam logic [5:0] FC_IPV6_FLABEL = 6'd27;
  localparam logic [5:0] FC_ICMP6_TYPE  = 6'd28;
  localparam logic [5:0] FC_ICMP6_CODE  = 6'd29;
  localparam logic [5:0] FC_ND_TARGET   = 6'd30;
  localparam logic [5:0] FC_ND_SLL      = 6'd31;
  localparam logic [5:0] FC_ND_TLL      = 6'd32;
  localparam logic [5:0] FC_MPLS_LABEL  = 6'd33;
  localparam logic [5:0] FC_MPLS_TC     = 6'd34;
  localparam logic [5:0] FC_MPLS_BOS    = 6'd35;
  localparam logic [5:0] FC_SUMMARY     = 6'd36;

  // frame status codes
  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_FRAGMENT  = 2'd2;
  localparam logic [1:0] ST_NON_SNAP  = 2'd3;

  // ether types and protocol numbers
  localparam logic [15:0] ET_VLAN   = 16'h8100;
  localparam logic [15:0] ET_QINQ   = 16'h88a8;
  localparam logic [15:0] ET_MPLS   = 16'h8847;
  localparam logic [15:0] ET_MPLS_M = 16'h8848;
  localparam logic [15:0] ET_ARP    = 16'h0806;
  localparam logic [15:0] ET_IPV4   = 16'h0800;
  localparam logic [15:0] ET_IPV6   = 16'h86dd;
  localparam logic [15:0] ET_MIN    = 16'h0600;

  localparam logic [7:0] PR_ICMP4 = 8'd1;
  localparam logic [7:0] PR_TCP   = 8'd6;
  localparam logic [7:0] PR_UDP   = 8'd17;
  localparam logic [7:0] PR_ICMP6 = 8'd58;
  localparam logic [7:0] PR_SCTP  = 8'd132;
  localparam logic [7:0] PR_HOP   = 8'd0;
  localparam logic [7:0] PR_ROUTE = 8'd43;
  localparam logic [7:0] PR_FRAG  = 8'd44;
  localparam logic [7:0] PR_AH    = 8'd51;
  localparam logic [7:0] PR_DEST  = 8'd60;

  typedef enum logic [4:0] {
    PH_ETH, PH_LLC, PH_VLAN, PH_MPLS, PH_MPLS_NEXT, PH_ARP, PH_IPV4, PH_IPV4_OPT,
    PH_IPV6, PH_EXT, PH_TCP, PH_UDP, PH_SCTP, PH_ICMP4, PH_ICMP6, PH_ND_TARGET,
    PH_ND_OPT, PH_DONE, PH_STOP
  } phase_t;

  typedef struct packed {
    logic [5:0]  code;
    logic [63:0] value;
    logic        upper;
    logic [1:0]  status;
    logic [2:0]  flags;
    logic        ttl_ok;
  } res_t;

  typedef struct packed {
    logic [2:0]              count;
    res_t [MaxRes-1:0]       item;
  } group_t;

  function automatic res_t mk_res(logic [5:0] code, logic [63:0] value, logic upper);
    res_t r;
    r.code   = code;
    r.value  = value;
    r.upper  = upper;
    r.status = ST_COMPLETE;
    r.flags  = 3'd0;
    r.ttl_ok = 1'b0;
    return r;
  endfunction

  // phase that follows an ether type
  function automatic phase_t route_phase(logic [15:0] t);
    phase_t p;
    if (t == ET_VLAN || t == ET_QINQ) p = PH_VLAN;
    else if (t == ET_MPLS || t == ET_MPLS_M) p = PH_MPLS;
    else if (t == ET_ARP) p = PH_ARP;
    else if (t == ET_IPV4) p = PH_IPV4;
    else if (t == ET_IPV6) p = PH_IPV6;
    else p = PH_DONE;
    return p;
  endfunction

  function automatic phase_t l4_phase(logic [7:0] proto, logic v6);
    phase_t p;
    if (proto == PR_TCP) p = PH_TCP;
    else if (proto == PR_UDP) p = PH_UDP;
    else if (proto == PR_SCTP) p = PH_SCTP;
    else if (!v6 && proto == PR_ICMP4) p = PH_ICMP4;
    else if (v6 && proto == PR_ICMP6) p = PH_ICMP6;
    else p = PH_DONE;
    return p;
  endfunction

  function automatic logic is_ext(logic [7:0] nh);
    return nh == PR_HOP || nh == PR_ROUTE || nh == PR_DEST || nh == PR_AH ||
           nh == PR_FRAG;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/phfe_parser.sv
// input register and single-pass header parser, one frame byte per item
`timescale 1ns / 1ps
`default_nettype none

module phfe_parser #(
  parameter int OFFSET_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [7:0]           in_byte,
  input  wire                  in_last,
  input  wire  [31:0]          in_port,
  input  wire  [15:0]          mtu_limit,
  output logic                 grp_valid,
  input  wire                  grp_ready,
  output phfe_pkg::group_t     grp
);

  // input register
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_last;
  logic [31:0] hold_port;

  // parse state
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  phfe_pkg::phase_t       phase, phase_next;
  logic [5:0]             hpos, hpos_next;
  logic [11:0]            rem, rem_next;
  logic [119:0]           win;
  logic [47:0]            vs0, vs0_next, vs1, vs1_next;
  logic [7:0]             next_type, next_type_next;
  logic [2:0]             frame_flags, frame_flags_next;
  logic                   ttl_fail, ttl_fail_next;
  logic [1:0]             nd_seen, nd_seen_next;
  logic [1:0]             frame_status, frame_status_next;
  logic [31:0]            port_hold, port_hold_next;
  logic                   tag_seen, tag_seen_next;
  logic                   label_seen, label_seen_next;
  logic [3:0]             ihl, ihl_next;
  logic [7:0]             ext_nh, ext_nh_next;
  logic                   arp_ok, arp_ok_next;
  logic                   arp_addr, arp_addr_next;

  // working signals
  logic [7:0]       b;
  logic [127:0]     w;
  phfe_pkg::phase_t ph, rt;
  logic [5:0]       hp, hpn;
  logic [11:0]      rdec;
  logic [2:0]       n;
  phfe_pkg::res_t   res [phfe_pkg::MaxRes];
  logic [31:0]      port_eff;
  logic [1:0]       st;
  logic [1:0]       bit_sel;
  logic             ok_c;
  logic [7:0]       base_c;
  logic [5:0]       end_c;
  phfe_pkg::res_t   summary;

  localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};

  logic consume;
  assign consume   = hold_valid && grp_ready;
  assign in_ready  = !hold_valid || grp_ready;
  assign grp_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (consume) begin
      hold_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
      hold_port <= in_port;
    end
  end

  assign b = hold_byte;
  assign w = {win, b};

  always_comb begin
    byte_offset_next  = byte_offset;
    vs0_next          = vs0;
    vs1_next          = vs1;
    next_type_next    = next_type;
    frame_flags_next  = frame_flags;
    ttl_fail_next     = ttl_fail;
    nd_seen_next      = nd_seen;
    frame_status_next = frame_status;
    tag_seen_next     = tag_seen;
    label_seen_next   = label_seen;
    ihl_next          = ihl;
    ext_nh_next       = ext_nh;
    arp_ok_next       = arp_ok;
    arp_addr_next     = arp_addr;
    n                 = 3'd0;
    rt                = phfe_pkg::PH_DONE;
    bit_sel           = 2'd0;
    ok_c              = 1'b0;
    base_c            = 8'd0;
    end_c             = 6'd0;
    st                = 2'd0;
    summary           = '0;
    for (int i = 0; i < phfe_pkg::MaxRes; i++) begin
      res[i] = '0;
    end

    port_eff       = (byte_offset == '0) ? hold_port : port_hold;
    port_hold_next = port_eff;

    // the byte after the bottom label picks the network header
    ph = phase;
    hp = hpos;
    if (phase == phfe_pkg::PH_MPLS_NEXT) begin
      hp = 6'd0;
      if (b[7:4] == 4'h4) ph = phfe_pkg::PH_IPV4;
      else if (b[7:4] == 4'h6) ph = phfe_pkg::PH_IPV6;
      else ph = phfe_pkg::PH_DONE;
    end
    hpn        = hp + 6'd1;
    phase_next = ph;
    hpos_next  = hp;
    rem_next   = (phase == phfe_pkg::PH_MPLS_NEXT) ? 12'd0 : rem;
    rdec       = (rem_next != 12'd0) ? rem_next - 12'd1 : 12'd0;

    case (ph)
      phfe_pkg::PH_ETH: begin
        hpos_next = hpn;
        if (hpn == 6'd14) begin
          vs0_next  = w[111:64];
          vs1_next  = w[63:16];
          hpos_next = 6'd0;
          rem_next  = 12'd0;
          if (w[15:0] >= phfe_pkg::ET_MIN) begin
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ETH_DST, {16'd0, w[111:64]}, 1'b0);
            n = n + 3'd1;
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ETH_SRC, {16'd0, w[63:16]}, 1'b0);
            n = n + 3'd1;
            rt = phfe_pkg::route_phase(w[15:0]);
            if (rt != phfe_pkg::PH_VLAN) begin
              res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ETH_TYPE, {48'd0, w[15:0]}, 1'b0);
              n = n + 3'd1;
            end
            phase_next = rt;
          end else begin
            phase_next = phfe_pkg::PH_LLC;
          end
        end
      end
      phfe_pkg::PH_LLC: begin
        hpos_next = hpn;
        if (hpn == 6'd8) begin
          hpos_next = 6'd0;
          rem_next  = 12'd0;
          if (w[63:16] == 48'haaaa03000000) begin
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ETH_DST, {16'd0, vs0}, 1'b0);
            n = n + 3'd1;
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ETH_SRC, {16'd0, vs1}, 1'b0);
            n = n + 3'd1;
            rt = phfe_pkg::route_phase(w[15:0]);
            if (rt != phfe_pkg::PH_VLAN) begin
              res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ETH_TYPE, {48'd0, w[15:0]}, 1'b0);
              n = n + 3'd1;
            end
            phase_next = rt;
          end else begin
            frame_status_next = phfe_pkg::ST_NON_SNAP;
            phase_next        = phfe_pkg::PH_STOP;
          end
        end
      end
      phfe_pkg::PH_VLAN: begin
        hpos_next = hpn;
        if (hpn == 6'd4) begin
          // only the outer tag gives vid and pcp
          if (!tag_seen) begin
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_VLAN_VID,
                                      {51'd0, 1'b1, w[27:16]}, 1'b0);
            n = n + 3'd1;
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_VLAN_PCP, {61'd0, w[31:29]}, 1'b0);
            n = n + 3'd1;
            tag_seen_next = 1'b1;
          end
          rt = phfe_pkg::route_phase(w[15:0]);
          if (rt != phfe_pkg::PH_VLAN) begin
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ETH_TYPE, {48'd0, w[15:0]}, 1'b0);
            n = n + 3'd1;
          end
          phase_next = rt;
          hpos_next  = 6'd0;
          rem_next   = 12'd0;
        end
      end
      phfe_pkg::PH_MPLS: begin
        hpos_next = hpn;
        if (hpn == 6'd4) begin
          if (!label_seen) begin
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_MPLS_LABEL, {44'd0, w[31:12]}, 1'b0);
            n = n + 3'd1;
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_MPLS_TC, {61'd0, w[11:9]}, 1'b0);
            n = n + 3'd1;
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_MPLS_BOS, {63'd0, w[8]}, 1'b0);
            n = n + 3'd1;
            if (w[7:0] <= 8'd1) ttl_fail_next = 1'b1;
            label_seen_next = 1'b1;
          end
          phase_next = w[8] ? phfe_pkg::PH_MPLS_NEXT : phfe_pkg::PH_MPLS;
          hpos_next  = 6'd0;
          rem_next   = 12'd0;
        end
      end
      phfe_pkg::PH_ARP: begin
        hpos_next = hpn;
        if (hpn == 6'd8) begin
          ok_c = w[63:48] == 16'd1 && w[47:32] == phfe_pkg::ET_IPV4 &&
                 w[31:24] == 8'd6 && w[23:16] == 8'd4;
          arp_ok_next   = ok_c;
          arp_addr_next = ok_c && (w[15:0] == 16'd1 || w[15:0] == 16'd2);
          if (ok_c && w[15:8] == 8'd0) begin
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ARP_OP, {48'd0, w[15:0]}, 1'b0);
            n = n + 3'd1;
          end
        end else if (hpn == 6'd14 && arp_addr) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ARP_SHA, {16'd0, w[47:0]}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd18 && arp_addr) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ARP_SPA, {32'd0, w[31:0]}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd24 && arp_addr) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ARP_THA, {16'd0, w[47:0]}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd28) begin
          if (arp_addr) begin
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ARP_TPA, {32'd0, w[31:0]}, 1'b0);
            n = n + 3'd1;
          end
          phase_next = phfe_pkg::PH_DONE;
          hpos_next  = 6'd0;
          rem_next   = 12'd0;
        end
      end
      phfe_pkg::PH_IPV4: begin
        hpos_next = hpn;
        if (hpn == 6'd1) begin
          ihl_next = b[3:0];
          if (b[3:0] > 4'd5) frame_flags_next[1] = 1'b1;
        end else if (hpn == 6'd2) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IP_DSCP, {58'd0, b[7:2]}, 1'b0);
          n = n + 3'd1;
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IP_ECN, {62'd0, b[1:0]}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd4) begin
          if (w[15:0] > mtu_limit) frame_flags_next[2] = 1'b1;
        end else if (hpn == 6'd8) begin
          if (w[13:0] != 14'd0) frame_flags_next[0] = 1'b1;
        end else if (hpn == 6'd9) begin
          if (b == 8'd0) ttl_fail_next = 1'b1;
        end else if (hpn == 6'd10) begin
          next_type_next = b;
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IP_PROTO, {56'd0, b}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd16) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IPV4_SRC, {32'd0, w[31:0]}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd20) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IPV4_DST, {32'd0, w[31:0]}, 1'b0);
          n = n + 3'd1;
          hpos_next = 6'd0;
          rem_next  = 12'd0;
          if (frame_flags[0]) begin
            frame_status_next = phfe_pkg::ST_FRAGMENT;
            phase_next        = phfe_pkg::PH_STOP;
          end else if (ihl > 4'd5) begin
            phase_next = phfe_pkg::PH_IPV4_OPT;
            rem_next   = {6'd0, ihl, 2'b00} - 12'd20;
          end else begin
            phase_next = phfe_pkg::l4_phase(next_type, 1'b0);
          end
        end
      end
      phfe_pkg::PH_IPV4_OPT: begin
        rem_next = rdec;
        if (rdec == 12'd0) begin
          phase_next = phfe_pkg::l4_phase(next_type, 1'b0);
          hpos_next  = 6'd0;
        end
      end
      phfe_pkg::PH_IPV6: begin
        hpos_next = hpn;
        if (hpn == 6'd4) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IP_DSCP, {58'd0, w[27:22]}, 1'b0);
          n = n + 3'd1;
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IP_ECN, {62'd0, w[21:20]}, 1'b0);
          n = n + 3'd1;
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IPV6_FLABEL, {44'd0, w[19:0]}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd7) begin
          next_type_next = b;
        end else if (hpn == 6'd8) begin
          if (b == 8'd0) ttl_fail_next = 1'b1;
        end else if (hpn == 6'd24) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IPV6_SRC, w[127:64], 1'b1);
          n = n + 3'd1;
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IPV6_SRC, w[63:0], 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd40) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IPV6_DST, w[127:64], 1'b1);
          n = n + 3'd1;
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IPV6_DST, w[63:0], 1'b0);
          n = n + 3'd1;
          hpos_next      = 6'd0;
          rem_next       = 12'd0;
          next_type_next = next_type;
          if (phfe_pkg::is_ext(next_type)) begin
            phase_next = phfe_pkg::PH_EXT;
          end else begin
            res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IP_PROTO, {56'd0, next_type}, 1'b0);
            n = n + 3'd1;
            phase_next = phfe_pkg::l4_phase(next_type, 1'b1);
          end
        end
      end
      phfe_pkg::PH_EXT: begin
        if (hp < 6'd2) begin
          hpos_next = hpn;
          if (hpn == 6'd2) begin
            ext_nh_next = w[15:8];
            if (next_type == phfe_pkg::PR_AH) rem_next = {2'd0, b, 2'b00} + 12'd6;
            else if (next_type == phfe_pkg::PR_FRAG) rem_next = 12'd6;
            else rem_next = {1'b0, b, 3'b000} + 12'd6;
          end
        end else begin
          rem_next = rdec;
          if (rdec == 12'd0) begin
            if (next_type == phfe_pkg::PR_FRAG) frame_flags_next[0] = 1'b1;
            hpos_next      = 6'd0;
            next_type_next = ext_nh;
            if (phfe_pkg::is_ext(ext_nh)) begin
              phase_next = phfe_pkg::PH_EXT;
            end else begin
              res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IP_PROTO, {56'd0, ext_nh}, 1'b0);
              n = n + 3'd1;
              phase_next = phfe_pkg::l4_phase(ext_nh, 1'b1);
            end
          end
        end
      end
      phfe_pkg::PH_TCP, phfe_pkg::PH_UDP, phfe_pkg::PH_SCTP: begin
        if (ph == phfe_pkg::PH_TCP) begin
          base_c = {2'd0, phfe_pkg::FC_TCP_SRC};
          end_c  = 6'd20;
        end else if (ph == phfe_pkg::PH_UDP) begin
          base_c = {2'd0, phfe_pkg::FC_UDP_SRC};
          end_c  = 6'd8;
        end else begin
          base_c = {2'd0, phfe_pkg::FC_SCTP_SRC};
          end_c  = 6'd12;
        end
        hpos_next = hpn;
        if (hpn == 6'd2) begin
          res[n] = phfe_pkg::mk_res(base_c[5:0], {48'd0, w[15:0]}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd4) begin
          res[n] = phfe_pkg::mk_res(base_c[5:0] + 6'd1, {48'd0, w[15:0]}, 1'b0);
          n = n + 3'd1;
        end
        if (hpn == end_c) begin
          phase_next = phfe_pkg::PH_DONE;
          hpos_next  = 6'd0;
          rem_next   = 12'd0;
        end
      end
      phfe_pkg::PH_ICMP4: begin
        hpos_next = hpn;
        if (hpn == 6'd1) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ICMP4_TYPE, {56'd0, b}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd2) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ICMP4_CODE, {56'd0, b}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd4) begin
          phase_next = phfe_pkg::PH_DONE;
          hpos_next  = 6'd0;
          rem_next   = 12'd0;
        end
      end
      phfe_pkg::PH_ICMP6: begin
        hpos_next = hpn;
        if (hpn == 6'd1) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ICMP6_TYPE, {56'd0, b}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd2) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ICMP6_CODE, {56'd0, b}, 1'b0);
          n = n + 3'd1;
        end else if (hpn == 6'd8) begin
          hpos_next = 6'd0;
          rem_next  = 12'd0;
          // neighbour solicitation or advertisement with code zero
          if (w[55:48] == 8'd0 && (w[63:56] == 8'd135 || w[63:56] == 8'd136))
            phase_next = phfe_pkg::PH_ND_TARGET;
          else
            phase_next = phfe_pkg::PH_DONE;
        end
      end
      phfe_pkg::PH_ND_TARGET: begin
        hpos_next = hpn;
        if (hpn == 6'd16) begin
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ND_TARGET, w[127:64], 1'b1);
          n = n + 3'd1;
          res[n] = phfe_pkg::mk_res(phfe_pkg::FC_ND_TARGET, w[63:0], 1'b0);
          n = n + 3'd1;
          nd_seen_next = 2'd0;
          phase_next   = phfe_pkg::PH_ND_OPT;
          hpos_next    = 6'd0;
          rem_next     = 12'd0;
        end
      end
      phfe_pkg::PH_ND_OPT: begin
        if (hp < 6'd8) begin
          hpos_next = hpn;
          if (hpn == 6'd2 && b == 8'd0) begin
            phase_next = phfe_pkg::PH_DONE;
            hpos_next  = 6'd0;
            rem_next   = 12'd0;
          end else if (hpn == 6'd8) begin
            ok_c    = 1'b1;
            bit_sel = (w[63:56] == 8'd1) ? 2'b01 : 2'b10;
            if (w[55:48] == 8'd1 && (w[63:56] == 8'd1 || w[63:56] == 8'd2)) begin
              if ((nd_seen & bit_sel) != 2'd0) begin
                // repeated address option ends option parsing
                ok_c       = 1'b0;
                phase_next = phfe_pkg::PH_DONE;
                hpos_next  = 6'd0;
                rem_next   = 12'd0;
              end else begin
                res[n] = phfe_pkg::mk_res(bit_sel[0] ? phfe_pkg::FC_ND_SLL :
                                          phfe_pkg::FC_ND_TLL, {16'd0, w[47:0]}, 1'b0);
                n = n + 3'd1;
                if (w[47:0] != 48'd0) nd_seen_next = nd_seen | bit_sel;
              end
            end
            if (ok_c) begin
              rem_next = {1'b0, w[55:48], 3'b000} - 12'd8;
              if (rem_next == 12'd0) hpos_next = 6'd0;
            end
          end
        end else begin
          rem_next = rdec;
          if (rdec == 12'd0) hpos_next = 6'd0;
        end
      end
      phfe_pkg::PH_DONE, phfe_pkg::PH_STOP: begin
      end
      default: begin
        phase_next = phfe_pkg::PH_DONE;
        hpos_next  = 6'd0;
        rem_next   = 12'd0;
      end
    endcase

    if (byte_offset != OffMax) byte_offset_next = byte_offset + 1'b1;

    if (hold_last) begin
      st = frame_status_next;
      if (st == phfe_pkg::ST_COMPLETE && phase_next != phfe_pkg::PH_DONE &&
          phase_next != phfe_pkg::PH_STOP && phase_next != phfe_pkg::PH_MPLS_NEXT &&
          phase_next != phfe_pkg::PH_ND_OPT)
        st = phfe_pkg::ST_TRUNCATED;
      res[n] = phfe_pkg::mk_res(phfe_pkg::FC_IN_PORT, {32'd0, port_eff}, 1'b0);
      n = n + 3'd1;
      res[n] = phfe_pkg::mk_res(phfe_pkg::FC_METADATA, 64'd0, 1'b0);
      n = n + 3'd1;
      summary        = phfe_pkg::mk_res(phfe_pkg::FC_SUMMARY, 64'd0, 1'b0);
      summary.status = st;
      summary.flags  = frame_flags_next;
      summary.ttl_ok = !ttl_fail_next;
      res[n] = summary;
      n = n + 3'd1;
      // rearm for the next frame
      byte_offset_next  = '0;
      phase_next        = phfe_pkg::PH_ETH;
      hpos_next         = 6'd0;
      rem_next          = 12'd0;
      vs0_next          = 48'd0;
      vs1_next          = 48'd0;
      next_type_next    = 8'd0;
      frame_flags_next  = 3'd0;
      ttl_fail_next     = 1'b0;
      nd_seen_next      = 2'd0;
      frame_status_next = phfe_pkg::ST_COMPLETE;
      port_hold_next    = 32'd0;
      tag_seen_next     = 1'b0;
      label_seen_next   = 1'b0;
    end

    grp.count = n;
    for (int i = 0; i < phfe_pkg::MaxRes; i++) begin
      grp.item[i] = res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      phase        <= phfe_pkg::PH_ETH;
      hpos         <= 6'd0;
      rem          <= 12'd0;
      vs0          <= 48'd0;
      vs1          <= 48'd0;
      next_type    <= 8'd0;
      frame_flags  <= 3'd0;
      ttl_fail     <= 1'b0;
      nd_seen      <= 2'd0;
      frame_status <= phfe_pkg::ST_COMPLETE;
      port_hold    <= 32'd0;
      tag_seen     <= 1'b0;
      label_seen   <= 1'b0;
      ihl          <= 4'd0;
      ext_nh       <= 8'd0;
      arp_ok       <= 1'b0;
      arp_addr     <= 1'b0;
    end else if (consume) begin
      byte_offset  <= byte_offset_next;
      phase        <= phase_next;
      hpos         <= hpos_next;
      rem          <= rem_next;
      vs0          <= vs0_next;
      vs1          <= vs1_next;
      next_type    <= next_type_next;
      frame_flags  <= frame_flags_next;
      ttl_fail     <= ttl_fail_next;
      nd_seen      <= nd_seen_next;
      frame_status <= frame_status_next;
      port_hold    <= port_hold_next;
      tag_seen     <= tag_seen_next;
      label_seen   <= label_seen_next;
      ihl          <= ihl_next;
      ext_nh       <= ext_nh_next;
      arp_ok       <= arp_ok_next;
      arp_addr     <= arp_addr_next;
    end
  end

  // window of the last fifteen bytes, header reads only touch bytes of the current header
  always_ff @(posedge clk) begin
    if (consume) begin
      win <= w[119:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/phfe_outbuf.sv
// result register holding one byte's group of results, drained one item a cycle while out_ready is high
`timescale 1ns / 1ps
`default_nettype none

module phfe_outbuf (
  input  wire               clk,
  input  wire               rst,
  input  wire               grp_valid,
  output logic              grp_ready,
  input  phfe_pkg::group_t  grp,
  output logic              out_valid,
  input  wire               out_ready,
  output phfe_pkg::res_t    out_item,
  output logic              out_last
);

  phfe_pkg::res_t slot [phfe_pkg::MaxRes];
  logic [2:0]     cnt;
  logic [2:0]     idx;
  logic           take;

  assign out_valid = idx != cnt;
  assign take      = out_valid && out_ready;
  assign grp_ready = !out_valid || (take && (idx + 3'd1 == cnt));
  assign out_item  = slot[idx[2:0] < 3'(phfe_pkg::MaxRes) ? idx : 3'd0];
  assign out_last  = idx + 3'd1 == cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      idx <= 3'd0;
    end else if (grp_valid && grp_ready) begin
      cnt <= grp.count;
      idx <= 3'd0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      for (int i = 0; i < phfe_pkg::MaxRes; i++) begin
        slot[i] <= grp.item[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/packet_header_field_extractor.sv
// path: an accepted byte passes the parser input register, then its results the result register
// throughput: one byte per cycle while each byte causes at most one result and m_axis_tready
//   stays high; a byte causing more than one result (up to six) holds the input until
//   the single result port has drained the result register, one item a cycle while m_axis_tready is high
// reset: synchronous rst clears parse state, mtu_limit returns to 1500
`timescale 1ns / 1ps
`default_nettype none

`include "packet_header_field_extractor_macros.svh"

module packet_header_field_extractor #(
  parameter int OFFSET_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // data_byte[7:0], in_port[39:8]
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // field_value[63:0], parse_status[65:64],
                                      // l3_flags[68:66], ttl_ok[69], zero[71:70]
  output logic [6:0]  m_axis_tuser,   // field_code[5:0], upper_half[6]
  output logic        m_axis_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data
);

  logic [15:0]      mtu_limit;
  logic             grp_valid;
  logic             grp_ready;
  phfe_pkg::group_t grp;
  phfe_pkg::res_t   out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu_limit <= 16'd1500;
    end else if (cfg_valid && cfg_ready) begin
      mtu_limit <= cfg_data;
    end
  end

  phfe_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata[7:0]),
    .in_last   (s_axis_tlast),
    .in_port   (s_axis_tdata[39:8]),
    .mtu_limit (mtu_limit),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  phfe_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_item.ttl_ok, out_item.flags, out_item.status,
                         out_item.value};
  assign m_axis_tuser = {out_item.upper, out_item.code};

  // the summary closes the group of its byte
  `PHFE_ASSERT_NOW(a_summary_last, m_axis_tvalid && out_item.code == phfe_pkg::FC_SUMMARY, m_axis_tlast, "summary item not marked last")

  // only the summary carries status, flags and ttl check
  `PHFE_ASSERT_NOW(a_plain_clean, m_axis_tvalid && out_item.code != phfe_pkg::FC_SUMMARY, m_axis_tdata[71:64] == 8'd0, "status bits on a field item")

  // an upper half is followed at once by the lower half of the same field
  `PHFE_ASSERT_NEXT(a_half_pair, m_axis_tvalid && m_axis_tready && out_item.upper, m_axis_tvalid && !out_item.upper && out_item.code == $past(out_item.code), "upper half not followed by lower half")

endmodule

`default_nettype wire
